// ===== rtl/challenge_nonce_table_top_assert.svh =====
// ---------------------------------------------------------------------------
// Nonce table assertion macros
// Shorthand for the clocked, reset-qualified properties used in the RTL.
// ---------------------------------------------------------------------------
`ifndef CHALLENGE_NONCE_TABLE_TOP_ASSERT_SVH
`define CHALLENGE_NONCE_TABLE_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled while arst_n is low.
`define CNT_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("nonce table assertion failed");

// Next-cycle implication, sampled on clk and disabled while arst_n is low.
`define CNT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("nonce table assertion failed");

`endif

// ===== rtl/cnt_pkg.sv =====
// ---------------------------------------------------------------------------
// Nonce table package
// Word types, action codes and defaults shared by the nonce table modules.
// ---------------------------------------------------------------------------
package cnt_pkg;

	localparam int TABLE_SLOTS_DEF      = 16;
	localparam int NONCE_DATA_BYTES_DEF = 32;
	localparam int SLOT_FIELD_W         = 4;

	typedef enum logic [1:0] {
		ACT_CLEAR   = 2'd0,
		ACT_RECORD  = 2'd1,
		ACT_CONSUME = 2'd2
	} action_t;

	typedef struct packed {
		logic [1:0]  action;
		logic [31:0] nonce_seq;
		logic [63:0] nonce_time;
		logic [63:0] nonce_word0;
		logic [63:0] nonce_word1;
		logic [63:0] nonce_word2;
		logic [63:0] nonce_word3;
	} req_t;

	typedef struct packed {
		logic                    matched;
		logic                    evicted;
		logic [SLOT_FIELD_W-1:0] slot_used;
	} rsp_t;

	typedef struct packed {
		logic idle;
		logic done;
		rsp_t res;
	} eng_status_t;

endpackage

// ===== rtl/challenge_nonce_table_top.sv =====
// ---------------------------------------------------------------------------
// Challenge nonce table
// Outstanding-nonce cache with lowest-free placement and round-robin eviction.
// ---------------------------------------------------------------------------
// Each request word is handled on its own and gives one response word. A clear,
// or a word with the unused action code, goes from acceptance straight to the
// done state. A record walks the valid bits one slot a cycle from slot 0 to
// the lowest free slot, or over all TABLE_SLOTS slots when the table is full,
// and then writes the entry. A consume reads the entry memory one slot a cycle
// and compares each entry in the next cycle, stopping at the first hit or,
// on a miss, after the last slot. The next request is taken once the response
// has moved into the output register, even while that register is still
// stalled.
// ---------------------------------------------------------------------------
module challenge_nonce_table_top #(
	parameter int TABLE_SLOTS      = cnt_pkg::TABLE_SLOTS_DEF,
	parameter int NONCE_DATA_BYTES = cnt_pkg::NONCE_DATA_BYTES_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  cnt_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output cnt_pkg::rsp_t rsp
);
	import cnt_pkg::*;

	eng_status_t status;
	logic        start;
	logic        take;
	logic        rsp_valid_q;
	rsp_t        rsp_q;

	assign req_stall = !status.idle;
	assign start     = req_valid && !req_stall;
	assign take      = status.done && (!rsp_valid_q || !rsp_stall);

	cnt_engine #(
		.TABLE_SLOTS      (TABLE_SLOTS),
		.NONCE_DATA_BYTES (NONCE_DATA_BYTES)
	) u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.item   (req),
		.take   (take),
		.status (status)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (take) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			rsp_q <= status.res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ===== rtl/cnt_engine.sv =====
// ---------------------------------------------------------------------------
// Nonce table engine
// Entry memory, valid bits, eviction pointer and the slot-scan sequencer.
// ---------------------------------------------------------------------------
`include "challenge_nonce_table_top_assert.svh"

module cnt_engine #(
	parameter int TABLE_SLOTS      = cnt_pkg::TABLE_SLOTS_DEF,
	parameter int NONCE_DATA_BYTES = cnt_pkg::NONCE_DATA_BYTES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  cnt_pkg::req_t        item,
	input  logic                 take,
	output cnt_pkg::eng_status_t status
);
	import cnt_pkg::*;

	localparam int IDX_W     = $clog2(TABLE_SLOTS);
	localparam int CNT_W     = $clog2(TABLE_SLOTS + 1);
	localparam int DATA_BITS = NONCE_DATA_BYTES * 8;
	localparam int KEY_W     = 32 + 64 + DATA_BITS;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_SCAN  = 4'b0010,
		ST_WRITE = 4'b0100,
		ST_DONE  = 4'b1000
	} state_t;

	state_t                 state_q;
	logic [1:0]             act_q;
	logic [CNT_W-1:0]       idx_q;
	logic [TABLE_SLOTS-1:0] valid_q;
	logic [IDX_W-1:0]       evict_q;
	logic                   pend_s1;
	logic [IDX_W-1:0]       tag_s1;
	logic [KEY_W-1:0]       rd_s1;
	logic [KEY_W-1:0]       key_q;
	logic [IDX_W-1:0]       target_q;
	logic                   evicted_q;
	rsp_t                   res_q;

	logic [KEY_W-1:0]       entry_mem_q [TABLE_SLOTS];

	logic [255:0]     data_full;
	logic [KEY_W-1:0] key;
	logic             at_end;
	logic             rd_en;
	logic             hit;

	function automatic logic [SLOT_FIELD_W-1:0] slot_field(input logic [IDX_W-1:0] i);
		logic [IDX_W+SLOT_FIELD_W-1:0] ext;
		ext = {{SLOT_FIELD_W{1'b0}}, i};
		return ext[SLOT_FIELD_W-1:0];
	endfunction

	// Data bytes beyond the configured width are dropped here, so they are
	// neither stored nor compared.
	always_comb begin
		data_full = {item.nonce_word3, item.nonce_word2, item.nonce_word1, item.nonce_word0};
		key       = {item.nonce_seq, item.nonce_time, data_full[DATA_BITS-1:0]};
	end

	assign at_end = (idx_q == CNT_W'(TABLE_SLOTS));
	assign rd_en  = (state_q == ST_SCAN) && (act_q == ACT_CONSUME) && !at_end;
	assign hit    = pend_s1 && valid_q[tag_s1] && (rd_s1 == key_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			act_q   <= ACT_CLEAR;
			idx_q   <= '0;
			valid_q <= '0;
			evict_q <= '0;
			pend_s1 <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						act_q   <= item.action;
						idx_q   <= '0;
						pend_s1 <= 1'b0;
						case (item.action)
							ACT_CLEAR: begin
								valid_q <= '0;
								evict_q <= '0;
								state_q <= ST_DONE;
							end
							ACT_RECORD, ACT_CONSUME: begin
								state_q <= ST_SCAN;
							end
							default: begin
								state_q <= ST_DONE;
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (act_q == ACT_RECORD) begin
						if (at_end) begin
							if (evict_q == IDX_W'(TABLE_SLOTS - 1)) begin
								evict_q <= '0;
							end else begin
								evict_q <= evict_q + IDX_W'(1);
							end
							state_q <= ST_WRITE;
						end else if (!valid_q[idx_q[IDX_W-1:0]]) begin
							state_q <= ST_WRITE;
						end else begin
							idx_q <= idx_q + CNT_W'(1);
						end
					end else begin
						// One slot is read per cycle; the compare works on the registered read word rd_s1.
						pend_s1 <= !at_end;
						if (!at_end) begin
							idx_q <= idx_q + CNT_W'(1);
						end
						if (hit) begin
							valid_q[tag_s1] <= 1'b0;
							state_q         <= ST_DONE;
						end else if (!pend_s1 && at_end) begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_WRITE: begin
					valid_q[target_q] <= 1'b1;
					state_q           <= ST_DONE;
				end
				ST_DONE: begin
					if (take) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			key_q <= key;
			res_q <= '0;
		end
		if (state_q == ST_SCAN) begin
			if (act_q == ACT_RECORD) begin
				if (at_end) begin
					target_q  <= evict_q;
					evicted_q <= 1'b1;
				end else if (!valid_q[idx_q[IDX_W-1:0]]) begin
					target_q  <= idx_q[IDX_W-1:0];
					evicted_q <= 1'b0;
				end
			end else begin
				tag_s1 <= idx_q[IDX_W-1:0];
				if (hit) begin
					res_q <= '{matched: 1'b1, evicted: 1'b0, slot_used: slot_field(tag_s1)};
				end
			end
		end
		if (state_q == ST_WRITE) begin
			res_q <= '{matched: 1'b0, evicted: evicted_q, slot_used: slot_field(target_q)};
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_WRITE) begin
			entry_mem_q[target_q] <= key_q;
		end
		if (rd_en) begin
			rd_s1 <= entry_mem_q[idx_q[IDX_W-1:0]];
		end
	end

	assign status.idle = (state_q == ST_IDLE);
	assign status.done = (state_q == ST_DONE);
	assign status.res  = res_q;

	`CNT_ASSERT_NOW(a_start_when_idle, start, state_q == ST_IDLE)
	`CNT_ASSERT_NEXT(a_write_sets_valid, state_q == ST_WRITE, valid_q[target_q])
	`CNT_ASSERT_NEXT(a_hit_frees_slot, state_q == ST_SCAN && act_q == ACT_CONSUME && hit,
		!valid_q[$past(tag_s1)] && state_q == ST_DONE)
	`CNT_ASSERT_NEXT(a_consume_keeps_pointer, state_q == ST_SCAN && act_q == ACT_CONSUME,
		$stable(evict_q))

endmodule
